[src/otbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-owner token bucket limiter: shared package
// Types and fixed constants used by the register block, the bucket memory
// and the request engine.
// ----------------------------------------------------------------------------
package otbl_pkg;

	// Fixed field widths.
	localparam int TOK_W  = 32;
	localparam int TIME_W = 48;
	localparam int CAP_W  = 20;
	localparam int RATE_REGS = 4;

	// Highest per-frame emit cap honored.
	localparam logic [CAP_W-1:0] CAP_MAX = 20'd1000000;

	// Action and kind codes.
	localparam logic ACT_FRAME   = 1'b0;
	localparam logic ACT_REQUEST = 1'b1;
	localparam logic [2:0] KIND_EMIT = 3'd4;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_LIFE_RATE    = 3'd0;
	localparam logic [2:0] REG_MANA_RATE    = 3'd1;
	localparam logic [2:0] REG_AILMENT_RATE = 3'd2;
	localparam logic [2:0] REG_TRIGGER_RATE = 3'd3;
	localparam logic [2:0] REG_EMIT_CAP     = 3'd4;

	// Configuration seen by the engine.
	typedef struct packed {
		logic [RATE_REGS-1:0][TOK_W-1:0] rate;
		logic [CAP_W-1:0]                emit_cap;
	} cfg_t;

	// One bucket entry as stored in memory.
	typedef struct packed {
		logic              valid;
		logic [TOK_W-1:0]  tokens;
		logic [TIME_W-1:0] stamp;
	} bucket_entry_t;

endpackage

[src/otbl_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the four kind rates and the emit cap.
// ----------------------------------------------------------------------------
module otbl_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output otbl_pkg::cfg_t      cfg
);

	logic [otbl_pkg::RATE_REGS-1:0][otbl_pkg::TOK_W-1:0] rate_q;
	logic [otbl_pkg::CAP_W-1:0]                          emit_cap_q;
	logic [2:0]                                          reg_idx;
	logic                                                wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= '0;
			emit_cap_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				otbl_pkg::REG_LIFE_RATE:    rate_q[0]  <= pwdata;
				otbl_pkg::REG_MANA_RATE:    rate_q[1]  <= pwdata;
				otbl_pkg::REG_AILMENT_RATE: rate_q[2]  <= pwdata;
				otbl_pkg::REG_TRIGGER_RATE: rate_q[3]  <= pwdata;
				otbl_pkg::REG_EMIT_CAP:     emit_cap_q <= pwdata[otbl_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data returns the stored value, zero outside the register list.
	always_comb begin
		case (reg_idx)
			otbl_pkg::REG_LIFE_RATE:    prdata = rate_q[0];
			otbl_pkg::REG_MANA_RATE:    prdata = rate_q[1];
			otbl_pkg::REG_AILMENT_RATE: prdata = rate_q[2];
			otbl_pkg::REG_TRIGGER_RATE: prdata = rate_q[3];
			otbl_pkg::REG_EMIT_CAP:     prdata = {12'd0, emit_cap_q};
			default:                    prdata = '0;
		endcase
	end

	assign cfg.rate     = rate_q;
	assign cfg.emit_cap = emit_cap_q;

endmodule

[src/otbl_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket memory
// Single-port-write, single-port-read synchronous memory of bucket entries
// with a registered read port.
// ----------------------------------------------------------------------------
module otbl_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [ADDR_W-1:0]              wr_addr,
	input  otbl_pkg::bucket_entry_t        wr_data,
	input  logic                           rd_en,
	input  logic [ADDR_W-1:0]              rd_addr,
	output otbl_pkg::bucket_entry_t        rd_data
);

	otbl_pkg::bucket_entry_t mem_q [DEPTH];
	otbl_pkg::bucket_entry_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/otbl_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request engine
// Handles begin-frame and request transfers, runs the read-modify-write of
// one bucket entry per request and holds the result in an output register.
// ----------------------------------------------------------------------------
module otbl_engine #(
	parameter int OWNER_COUNT  = 256,
	parameter int BUCKET_KINDS = 4,
	parameter int FRAC_BITS    = 16,
	parameter int SLOTS        = 1024,
	parameter int SLOT_W       = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  otbl_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [7:0]                    owner_id,
	input  logic                          owner_null,
	input  logic [2:0]                    kind,
	input  logic [31:0]                   cost,
	input  logic [31:0]                   frame_dt,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          granted,
	output logic                          mem_wr_en,
	output logic [SLOT_W-1:0]             mem_wr_addr,
	output otbl_pkg::bucket_entry_t       mem_wr_data,
	output logic                          mem_rd_en,
	output logic [SLOT_W-1:0]             mem_rd_addr,
	input  otbl_pkg::bucket_entry_t       mem_rd_data
);

	localparam int TOK_W  = otbl_pkg::TOK_W;
	localparam int TIME_W = otbl_pkg::TIME_W;
	localparam int PROD_W = FRAC_BITS + TOK_W;
	localparam logic [TOK_W:0] EPS_Q =
		(TOK_W + 1)'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_SUM,
		ST_FINAL,
		ST_DONE
	} state_t;

	state_t state_q;

	// Frame state.
	logic [TIME_W-1:0]          now_q;
	logic                       frame_begun_q;
	logic [otbl_pkg::CAP_W-1:0] emits_q;

	// Memory clearing pass after reset.
	logic                       clearing_q;
	logic [SLOT_W-1:0]          clr_addr_q;

	// Request held while its bucket is worked on.
	logic [SLOT_W-1:0]          slot_q;
	logic [TOK_W-1:0]           rate_q;
	logic [TOK_W-1:0]           cost_q;
	logic                       result_q;

	// Pipeline registers of the refill.
	logic [TIME_W-1:0]          diff_s1;
	logic [TOK_W-1:0]           tokens_s1;
	logic                       valid_s1;
	logic [PROD_W-1:0]          prod_s2;
	logic [TOK_W-1:0]           tokens_s2;
	logic                       valid_s2;
	logic                       diff_zero_s2;
	logic                       diff_big_s2;
	logic [TOK_W-1:0]           fill_s3;

	// Output register.
	logic                       out_valid_q;
	logic                       granted_q;

	// Combinational helpers.
	logic                       accept;
	logic                       out_free;
	logic [7:0]                 owner_lut [256];
	logic [7:0]                 owner_mod;
	logic [31:0]                slot_full;
	logic [TOK_W-1:0]           rate_sel;
	logic [otbl_pkg::CAP_W-1:0] cap_sat;
	logic                       need_bucket;
	logic                       fast_grant;
	logic [TOK_W:0]             refill_sum;
	logic [TOK_W-1:0]           fill_next;
	logic                       deny_final;
	logic [TOK_W-1:0]           tokens_final;

	// Owner index modulo the owner count, from a constant table.
	for (genvar g = 0; g < 256; g++) begin : g_owner_lut
		assign owner_lut[g] = 8'(g % OWNER_COUNT);
	end

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || clearing_q;
	assign out_free = !out_valid_q || !out_stall;

	// Bucket slot of the incoming request.
	assign owner_mod = owner_lut[owner_id];
	assign slot_full = 32'(owner_mod) * 32'(BUCKET_KINDS) + 32'(kind);

	// Rate of the requested kind; kinds beyond the bucket set read as zero.
	always_comb begin
		rate_sel = '0;
		if ((32'(kind) < 32'(BUCKET_KINDS)) && (kind < 3'(otbl_pkg::RATE_REGS))) begin
			rate_sel = cfg.rate[kind[1:0]];
		end
	end

	assign cap_sat = (cfg.emit_cap > otbl_pkg::CAP_MAX) ? otbl_pkg::CAP_MAX : cfg.emit_cap;

	// Decide at acceptance whether the request settles without its bucket.
	always_comb begin
		need_bucket = 1'b0;
		fast_grant  = 1'b1;
		if (!frame_begun_q) begin
			fast_grant = 1'b1;
		end else if (kind == otbl_pkg::KIND_EMIT) begin
			fast_grant = (cap_sat != '0) && (emits_q < cap_sat);
		end else if (owner_null) begin
			fast_grant = 1'b1;
		end else if ({1'b0, cost} <= EPS_Q) begin
			fast_grant = 1'b1;
		end else if ({1'b0, rate_sel} <= EPS_Q) begin
			fast_grant = 1'b0;
		end else begin
			need_bucket = 1'b1;
		end
	end

	// Refill: add the earned tokens and saturate at the rate.
	assign refill_sum = {1'b0, tokens_s2} + {1'b0, prod_s2[PROD_W-1:FRAC_BITS]};
	always_comb begin
		if (!valid_s2) begin
			fill_next = rate_q;
		end else if (diff_zero_s2) begin
			fill_next = tokens_s2;
		end else if (diff_big_s2) begin
			fill_next = rate_q;
		end else if (refill_sum > {1'b0, rate_q}) begin
			fill_next = rate_q;
		end else begin
			fill_next = refill_sum[TOK_W-1:0];
		end
	end

	// Charge the cost against the refilled bucket.
	assign deny_final   = ({1'b0, fill_s3} + EPS_Q) < {1'b0, cost_q};
	assign tokens_final = deny_final ? fill_s3 :
		((fill_s3 >= cost_q) ? (fill_s3 - cost_q) : '0);

	// Memory ports: the clearing pass owns the write port until it ends.
	assign mem_rd_en   = accept && (action == otbl_pkg::ACT_REQUEST) && need_bucket;
	assign mem_rd_addr = slot_full[SLOT_W-1:0];
	always_comb begin
		if (clearing_q) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = clr_addr_q;
			mem_wr_data = '0;
		end else begin
			mem_wr_en          = (state_q == ST_FINAL);
			mem_wr_addr        = slot_q;
			mem_wr_data.valid  = 1'b1;
			mem_wr_data.tokens = tokens_final;
			mem_wr_data.stamp  = now_q;
		end
	end

	// State, frame counters and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			now_q         <= '0;
			frame_begun_q <= 1'b0;
			emits_q       <= '0;
			clearing_q    <= 1'b1;
			clr_addr_q    <= '0;
			out_valid_q   <= 1'b0;
			result_q      <= 1'b0;
			granted_q     <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_addr_q == SLOT_W'(SLOTS - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end

			// The output register fills from a finished result and empties
			// on a result transfer.
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == otbl_pkg::ACT_FRAME) begin
							now_q         <= now_q + TIME_W'(frame_dt);
							emits_q       <= '0;
							frame_begun_q <= 1'b1;
						end else if (need_bucket) begin
							state_q <= ST_READ;
						end else begin
							if (frame_begun_q && (kind == otbl_pkg::KIND_EMIT) && fast_grant) begin
								emits_q <= emits_q + 1'b1;
							end
							result_q <= fast_grant;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_READ:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_FINAL;
				ST_FINAL: begin
					result_q <= !deny_final;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						granted_q <= result_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request payload and refill pipeline.
	always_ff @(posedge clk) begin
		if (mem_rd_en) begin
			slot_q <= slot_full[SLOT_W-1:0];
			rate_q <= rate_sel;
			cost_q <= cost;
		end
		if (state_q == ST_READ) begin
			diff_s1   <= now_q - mem_rd_data.stamp;
			tokens_s1 <= mem_rd_data.tokens;
			valid_s1  <= mem_rd_data.valid;
		end
		if (state_q == ST_MUL) begin
			prod_s2      <= PROD_W'(diff_s1[FRAC_BITS-1:0]) * PROD_W'(rate_q);
			tokens_s2    <= tokens_s1;
			valid_s2     <= valid_s1;
			diff_zero_s2 <= (diff_s1 == '0);
			diff_big_s2  <= |diff_s1[TIME_W-1:FRAC_BITS];
		end
		if (state_q == ST_SUM) begin
			fill_s3 <= fill_next;
		end
	end

	assign out_valid = out_valid_q;
	assign granted   = granted_q;

endmodule

[src/per_owner_token_bucket_limiter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-owner token bucket limiter
// Grants or denies requests against per-owner token buckets kept in memory.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A begin-frame transfer gives no result. A
// request that settles without its bucket (before the first frame, null
// owner, tiny cost, tiny rate, event emit) goes straight to its result; a
// request that uses its bucket runs the read-modify-write of the bucket
// memory: read, time difference, multiply, refill, charge and write back,
// result. After reset the bucket memory is cleared one entry a cycle, one
// pass over all OWNER_COUNT * BUCKET_KINDS entries, and no input transfer
// is taken until that pass ends; register writes are taken throughout. A
// finished result waits in an output register.
// ----------------------------------------------------------------------------
module per_owner_token_bucket_limiter_top #(
	parameter int OWNER_COUNT  = 256,
	parameter int BUCKET_KINDS = 4,
	parameter int FRAC_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  owner_id,
	input  logic        owner_null,
	input  logic [2:0]  kind,
	input  logic [31:0] cost,
	input  logic [31:0] frame_dt,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        granted,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SLOTS  = OWNER_COUNT * BUCKET_KINDS;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	otbl_pkg::cfg_t          cfg;
	logic                    mem_wr_en;
	logic [SLOT_W-1:0]       mem_wr_addr;
	otbl_pkg::bucket_entry_t mem_wr_data;
	logic                    mem_rd_en;
	logic [SLOT_W-1:0]       mem_rd_addr;
	otbl_pkg::bucket_entry_t mem_rd_data;

	// Configuration registers.
	otbl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Bucket storage.
	otbl_mem #(
		.DEPTH  (SLOTS),
		.ADDR_W (SLOT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Request engine.
	otbl_engine #(
		.OWNER_COUNT  (OWNER_COUNT),
		.BUCKET_KINDS (BUCKET_KINDS),
		.FRAC_BITS    (FRAC_BITS),
		.SLOTS        (SLOTS),
		.SLOT_W       (SLOT_W)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.owner_id    (owner_id),
		.owner_null  (owner_null),
		.kind        (kind),
		.cost        (cost),
		.frame_dt    (frame_dt),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.granted     (granted),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

endmodule

[verif/limiter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token bucket limiter checker
// Watches the register port, the request channel and the result channel. It
// keeps its own copy of the clock, the emit count and every bucket, works out
// the grant decision for each accepted request, and compares every result
// transfer with the oldest decision still owed.
// ----------------------------------------------------------------------------
module limiter_checker #(
	parameter int OWNER_COUNT  = 256,
	parameter int BUCKET_KINDS = 4,
	parameter int FRAC_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        action,
	input  logic [7:0]  owner_id,
	input  logic        owner_null,
	input  logic [2:0]  kind,
	input  logic [31:0] cost,
	input  logic [31:0] frame_dt,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        granted,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          grants_owed
);

	localparam int          SLOT_COUNT = OWNER_COUNT * BUCKET_KINDS;
	localparam logic [63:0] ONE_SECOND = 64'd1 << FRAC_BITS;
	// Smallest amount that counts: 0.0001 s rounded to the fraction grid.
	localparam logic [63:0] EPSILON    = (ONE_SECOND + 64'd5000) / 64'd10000;

	// Register copies, updated from observed register writes.
	logic [otbl_pkg::TOK_W-1:0]  rate_cfg [otbl_pkg::RATE_REGS];
	logic [otbl_pkg::CAP_W-1:0]  emit_cap_cfg;

	// Frame clock and per-frame emit count.
	logic [otbl_pkg::TIME_W-1:0] clock_now;
	logic                        frame_open;
	logic [otbl_pkg::CAP_W-1:0]  emit_count;

	// Bucket store, one entry per owner and kind.
	logic                        slot_used   [SLOT_COUNT];
	logic [otbl_pkg::TOK_W-1:0]  slot_tokens [SLOT_COUNT];
	logic [otbl_pkg::TIME_W-1:0] slot_stamp  [SLOT_COUNT];

	// Grant decisions waiting for their result transfer.
	bit grant_q [$];

	// Decides one request and charges the bucket it uses.
	function automatic bit decide_request(input logic [7:0] owner, input logic no_owner,
		input logic [2:0] req_kind, input logic [31:0] req_cost);
		logic [otbl_pkg::CAP_W-1:0]  cap;
		logic [63:0]                 rate;
		logic [otbl_pkg::TIME_W-1:0] gap48;
		logic [63:0]                 diff;
		logic [63:0]                 fill;
		int                          slot;
		if (!frame_open)
			return 1'b1;
		if (req_kind == otbl_pkg::KIND_EMIT) begin
			cap = (emit_cap_cfg > otbl_pkg::CAP_MAX) ? otbl_pkg::CAP_MAX : emit_cap_cfg;
			if (cap == '0 || emit_count >= cap)
				return 1'b0;
			emit_count++;
			return 1'b1;
		end
		if (no_owner)
			return 1'b1;
		if (64'(req_cost) <= EPSILON)
			return 1'b1;
		rate = (req_kind < BUCKET_KINDS && req_kind < otbl_pkg::RATE_REGS) ?
			64'(rate_cfg[req_kind]) : 64'd0;
		if (rate <= EPSILON)
			return 1'b0;
		slot = (int'(owner) % OWNER_COUNT) * BUCKET_KINDS + int'(req_kind);

		// First use fills the bucket; later uses refill by elapsed time.
		if (!slot_used[slot]) begin
			slot_used[slot]   = 1'b1;
			slot_tokens[slot] = rate[otbl_pkg::TOK_W-1:0];
			slot_stamp[slot]  = clock_now;
		end else begin
			gap48 = clock_now - slot_stamp[slot];
			diff  = 64'(gap48);
			if (diff != 0) begin
				if (diff >= ONE_SECOND) begin
					fill = rate;
				end else begin
					fill = 64'(slot_tokens[slot]) + ((diff * rate) >> FRAC_BITS);
					if (fill > rate)
						fill = rate;
				end
				slot_tokens[slot] = fill[otbl_pkg::TOK_W-1:0];
				slot_stamp[slot]  = clock_now;
			end
		end

		// Charge the cost, allowing a shortfall up to epsilon.
		if (64'(slot_tokens[slot]) + EPSILON < 64'(req_cost))
			return 1'b0;
		slot_tokens[slot] = (slot_tokens[slot] >= req_cost) ? slot_tokens[slot] - req_cost : '0;
		return 1'b1;
	endfunction

	// Counts a mismatch and reports the first few.
	task automatic report_mismatch(input string what, input bit want, input logic got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s, granted expected %0b got %0b", $realtime, what, want,
				got);
	endtask

	// Observe all three ports at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < otbl_pkg::RATE_REGS; i++)
				rate_cfg[i] = '0;
			emit_cap_cfg = '0;
			clock_now    = '0;
			frame_open   = 1'b0;
			emit_count   = '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_used[i]   = 1'b0;
				slot_tokens[i] = '0;
				slot_stamp[i]  = '0;
			end
			grant_q.delete();
			mismatches  = 0;
			grants_owed = 0;
		end else begin
			// A result transfer settles the oldest decision owed.
			if (out_valid && !out_stall) begin
				if (grant_q.size() == 0) begin
					report_mismatch("result with no request owed", 1'b0, granted);
				end else begin
					if (granted !== grant_q[0])
						report_mismatch("wrong decision", grant_q[0], granted);
					void'(grant_q.pop_front());
				end
			end

			// Register writes.
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					otbl_pkg::REG_LIFE_RATE:    rate_cfg[0]  = pwdata;
					otbl_pkg::REG_MANA_RATE:    rate_cfg[1]  = pwdata;
					otbl_pkg::REG_AILMENT_RATE: rate_cfg[2]  = pwdata;
					otbl_pkg::REG_TRIGGER_RATE: rate_cfg[3]  = pwdata;
					otbl_pkg::REG_EMIT_CAP:     emit_cap_cfg = pwdata[otbl_pkg::CAP_W-1:0];
					default: ;
				endcase
			end

			// An input transfer either starts a frame or owes a decision.
			if (in_valid && !in_stall) begin
				if (action == otbl_pkg::ACT_FRAME) begin
					clock_now  = clock_now + otbl_pkg::TIME_W'(frame_dt);
					emit_count = '0;
					frame_open = 1'b1;
				end else begin
					grant_q.push_back(decide_request(owner_id, owner_null, kind, cost));
				end
			end
			grants_owed = grant_q.size();
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token bucket limiter testbench
// Writes several rate and emit cap settings, sends a directed set of requests
// and frames and then random traffic over a few owners, with bursty input and
// a stalling receiver. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LIMIT       = 400000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 286;
	localparam int HOLD_CYCLES = 400;

	// Bucket kinds.
	localparam logic [2:0] KIND_LIFE    = 3'd0;
	localparam logic [2:0] KIND_MANA    = 3'd1;
	localparam logic [2:0] KIND_AILMENT = 3'd2;
	localparam logic [2:0] KIND_TRIGGER = 3'd3;
	localparam logic [2:0] KIND_LAST    = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [7:0]  owner_id;
	logic        owner_null;
	logic [2:0]  kind;
	logic [31:0] cost;
	logic [31:0] frame_dt;
	logic        out_valid;
	logic        out_stall;
	logic        granted;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches;
	int          grants_owed;

	// Rates last written, used to aim costs near the bucket size.
	logic [31:0] rate_set [otbl_pkg::RATE_REGS];
	logic [7:0]  owner_pool [4];
	int          burst_left;
	int          cycle_count;

	per_owner_token_bucket_limiter_top uut (.*);
	limiter_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Receiver: stall modes in random segments, plus one long hold-off that
	// lets the block fill up while requests keep coming.
	initial begin : receiver
		int seg_left;
		int mode;
		int taken;
		bit held;
		out_stall <= 1'b0;
		seg_left = 0;
		mode     = 0;
		taken    = 0;
		held     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				taken++;
			if (!held && taken >= 150) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (seg_left == 0) begin
				seg_left = $urandom_range(16, 80);
				mode     = $urandom_range(0, 3);
			end
			seg_left--;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= (seg_left % 2 == 0);
			endcase
		end
	end

	// Sends one item, opening a new burst after a random gap when due.
	task automatic send_item(input logic act, input logic [7:0] own, input logic no_own,
		input logic [2:0] knd, input logic [31:0] cst, input logic [31:0] dt);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		action     <= act;
		owner_id   <= own;
		owner_null <= no_own;
		kind       <= knd;
		cost       <= cst;
		frame_dt   <= dt;
		do @(posedge clk); while (in_stall);
	endtask

	// One register write: setup cycle, then access cycle.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx < otbl_pkg::RATE_REGS)
			rate_set[idx] = value;
	endtask

	task automatic set_config(input logic [31:0] life, input logic [31:0] mana,
		input logic [31:0] ailment, input logic [31:0] trigger, input logic [31:0] cap);
		write_reg(otbl_pkg::REG_LIFE_RATE, life);
		write_reg(otbl_pkg::REG_MANA_RATE, mana);
		write_reg(otbl_pkg::REG_AILMENT_RATE, ailment);
		write_reg(otbl_pkg::REG_TRIGGER_RATE, trigger);
		write_reg(otbl_pkg::REG_EMIT_CAP, cap);
	endtask

	// Waits until every owed result is in and the block has gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (grants_owed != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 8);
			1: return 32'($urandom_range(1, 16)) << 16;
			2: return $urandom_range(32'h100, 32'h1_0000);
			3: return $urandom;
			4: return 32'hFFFF_FFFF;
			default: return 32'($urandom_range(1, 4)) << 14;
		endcase
	endfunction

	// Random traffic: mostly requests on a few owners so buckets are reused
	// and refilled, with frames of mostly short steps in between.
	task automatic random_item();
		logic        act;
		logic        no_own;
		logic [7:0]  own;
		logic [2:0]  knd;
		logic [31:0] cst;
		logic [31:0] dt;
		logic [31:0] r;
		act    = ($urandom_range(0, 99) < 12) ? otbl_pkg::ACT_FRAME : otbl_pkg::ACT_REQUEST;
		own    = ($urandom_range(0, 9) < 8) ? owner_pool[$urandom_range(0, 3)] : 8'($urandom);
		no_own = ($urandom_range(0, 9) == 0);
		case ($urandom_range(0, 9))
			0: knd = otbl_pkg::KIND_EMIT;
			1: knd = 3'($urandom_range(otbl_pkg::KIND_EMIT + 1, KIND_LAST));
			default: knd = 3'($urandom_range(KIND_LIFE, KIND_TRIGGER));
		endcase
		r = (knd < otbl_pkg::RATE_REGS) ? rate_set[knd] : 32'd0;
		case ($urandom_range(0, 7))
			0: cst = $urandom_range(0, 8);
			1: cst = $urandom;
			2: cst = r;
			3: cst = r + $urandom_range(0, 15);
			4: cst = $urandom_range(8, 32'h2_0000);
			default: cst = r >> $urandom_range(1, 5);
		endcase
		case ($urandom_range(0, 9))
			0: dt = 32'd0;
			1: dt = $urandom_range(32'h1_0000, 32'h4_0000);
			2: dt = $urandom;
			default: dt = $urandom_range(1, 32'h6000);
		endcase
		send_item(act, own, no_own, knd, cst, dt);
	endtask

	initial begin : stimulus
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= otbl_pkg::ACT_REQUEST;
		owner_id   <= '0;
		owner_null <= 1'b0;
		kind       <= KIND_LIFE;
		cost       <= '0;
		frame_dt   <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		burst_left = 0;
		for (int i = 0; i < otbl_pkg::RATE_REGS; i++)
			rate_set[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Life at full scale, mana one per second, ailment at epsilon,
		// trigger just above it, two emits per frame.
		set_config(32'hFFFF_FFFF, 32'h0001_0000, 32'd7, 32'd8, 32'd2);

		// Before the first frame everything is granted.
		send_item(otbl_pkg::ACT_REQUEST, 8'd0, 1'b0, KIND_LIFE, 32'hFFFF_FFFF, 32'd0);
		send_item(otbl_pkg::ACT_REQUEST, 8'd9, 1'b0, otbl_pkg::KIND_EMIT, 32'd100,
			32'hFFFF_FFFF);
		send_item(otbl_pkg::ACT_REQUEST, 8'd255, 1'b0, KIND_LAST, 32'hFFFF_FFFF, 32'd0);
		send_item(otbl_pkg::ACT_FRAME, 8'd0, 1'b0, KIND_LIFE, 32'd0, 32'd0);
		// First use fills the bucket, exact cost empties it.
		send_item(otbl_pkg::ACT_REQUEST, 8'd1, 1'b0, KIND_MANA, 32'h0001_0000, 32'd0);
		// Shortfall just past epsilon, then a cost at epsilon.
		send_item(otbl_pkg::ACT_REQUEST, 8'd1, 1'b0, KIND_MANA, 32'd8, 32'd0);
		send_item(otbl_pkg::ACT_REQUEST, 8'd1, 1'b0, KIND_MANA, 32'd7, 32'd0);
		// Rate at epsilon denies; rate just above it fills and drains.
		send_item(otbl_pkg::ACT_REQUEST, 8'd2, 1'b0, KIND_AILMENT, 32'h100, 32'd0);
		send_item(otbl_pkg::ACT_REQUEST, 8'd3, 1'b0, KIND_TRIGGER, 32'd8, 32'd0);
		// No owner, and an unused kind with and without an owner.
		send_item(otbl_pkg::ACT_REQUEST, 8'd4, 1'b1, KIND_LIFE, 32'hFFFF_FFFF, 32'd0);
		send_item(otbl_pkg::ACT_REQUEST, 8'd4, 1'b1, otbl_pkg::KIND_EMIT + 3'd1, 32'd100,
			32'd0);
		send_item(otbl_pkg::ACT_REQUEST, 8'd4, 1'b0, KIND_LAST - 3'd1, 32'd100, 32'd0);
		// Emit cap of two per frame.
		send_item(otbl_pkg::ACT_REQUEST, 8'd5, 1'b1, otbl_pkg::KIND_EMIT, 32'd0, 32'd0);
		send_item(otbl_pkg::ACT_REQUEST, 8'd5, 1'b0, otbl_pkg::KIND_EMIT, 32'd0, 32'd0);
		send_item(otbl_pkg::ACT_REQUEST, 8'd5, 1'b0, otbl_pkg::KIND_EMIT, 32'd0, 32'd0);
		// Half a second refills half a bucket and resets the emit count.
		send_item(otbl_pkg::ACT_FRAME, 8'd0, 1'b0, KIND_LIFE, 32'd0, 32'h0000_8000);
		send_item(otbl_pkg::ACT_REQUEST, 8'd1, 1'b0, KIND_MANA, 32'h0000_8000, 32'd0);
		send_item(otbl_pkg::ACT_REQUEST, 8'd5, 1'b0, otbl_pkg::KIND_EMIT, 32'd0, 32'd0);
		// Longest frame step gives full buckets.
		send_item(otbl_pkg::ACT_FRAME, 8'd0, 1'b0, KIND_LIFE, 32'd0, 32'hFFFF_FFFF);
		send_item(otbl_pkg::ACT_REQUEST, 8'd0, 1'b0, KIND_LIFE, 32'hFFFF_FFFF, 32'd0);
		send_item(otbl_pkg::ACT_REQUEST, 8'd1, 1'b0, KIND_MANA, 32'h0001_0008, 32'd0);
		send_item(otbl_pkg::ACT_REQUEST, 8'd1, 1'b0, KIND_MANA, 32'h0001_0007, 32'd0);
		send_item(otbl_pkg::ACT_REQUEST, 8'd255, 1'b0, KIND_TRIGGER, 32'd9, 32'd0);

		// Random phases, each with its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: set_config(pick_rate(), pick_rate(), pick_rate(), pick_rate(),
					$urandom_range(1, 6));
				1: set_config(32'd0, 32'hFFFF_FFFF, 32'd7, 32'd8, 32'd0);
				2: set_config(pick_rate(), pick_rate(), pick_rate(), pick_rate(),
					32'hFFFF_FFFF);
				3: set_config(pick_rate(), pick_rate(), pick_rate(), pick_rate(),
					32'h0010_0003);
				default: set_config(pick_rate(), pick_rate(), pick_rate(), pick_rate(),
					$urandom_range(0, 8));
			endcase
			for (int k = 0; k < 4; k++)
				owner_pool[k] = 8'($urandom);
			repeat (PHASE_ITEMS) random_item();
		end

		settle();
		if (mismatches == 0 && grants_owed == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
